FILE: sv/mfkt_pkg.sv
// package for the most frequent key tracker: field widths, beat structs and codes
// no dependencies
package mfkt_pkg;

   localparam int KEY_SLOTS = 16;
   localparam int ROW_COUNT = 64;
   localparam int KEY_BITS  = 16;
   localparam int SLOT_W    = $clog2(KEY_SLOTS);
   localparam int CNT_W     = $clog2(ROW_COUNT + 1);
   localparam int AGE_W     = SLOT_W;
   localparam int ROW_W     = $clog2(ROW_COUNT);

   localparam logic [1:0] CMD_ADD    = 2'd0;
   localparam logic [1:0] CMD_REMOVE = 2'd1;
   localparam logic [1:0] CMD_QUERY  = 2'd2;
   localparam logic [1:0] CMD_UNDEF  = 2'd3;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_EMPTY = 2'd2;

   typedef struct packed {
      logic [1:0]  command;
      logic [15:0] key;
      logic [5:0]  row;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [15:0] key_res;
      logic [5:0]  row_res;
      logic [6:0]  frequency;
      logic        last;
   } rsp_type;

   // one slot entry as stored in the table memory
   typedef struct packed {
      logic [KEY_BITS-1:0]  key;
      logic [ROW_COUNT-1:0] rows;
      logic [CNT_W-1:0]     count;
      logic [AGE_W-1:0]     age;
   } entry_type;

   typedef enum logic [3:0] {
      S_IDLE, S_FIND, S_DECIDE, S_BITS, S_AGE_RD, S_AGE_WR,
      S_QSCAN, S_QREAD, S_QEMIT
   } state_type;

endpackage

FILE: sv/mfkt_table.sv
// slot table memory: one synchronous read port, one write port, read data registered
// depends on mfkt_pkg
module mfkt_table (
   input  logic                       clock,
   input  logic [mfkt_pkg::SLOT_W-1:0] rd_addr,
   output mfkt_pkg::entry_type         rd_data,
   input  logic                       wr_en,
   input  logic [mfkt_pkg::SLOT_W-1:0] wr_addr,
   input  mfkt_pkg::entry_type         wr_data
);
   import mfkt_pkg::*;

   entry_type mem_ff [KEY_SLOTS];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

FILE: sv/most_frequent_key_tracker.sv
// top level of the most frequent key tracker: sequencer around the slot table
// depends on mfkt_pkg and mfkt_table
//
// One command at a time; busy stays high until the command is fully processed, which
// for an add or remove that changes the table is well after its result beat. The slot
// table is a single-port-read memory and every pass walks all KEY_SLOTS entries. After
// the accept cycle, an add or remove that changes the table runs a lookup pass reading
// one slot at a time, decide, slot write, then an age pass that reads and writes back
// each slot, with its result beat in the decide cycle; a dropped add or a remove of an
// unknown key ends after the lookup pass and decide. A query runs a max search, a read
// state, then a scan of every row bit; an empty query gives its empty beat with no
// search, and an undefined command is taken and ignored. Result beats
// appear on rsp_valid for one cycle each and cannot be stalled. No clearing pass after
// reset: slot validity is held in flip-flops.
module most_frequent_key_tracker (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  mfkt_pkg::req_type req_data,
   output logic              rsp_valid,
   output mfkt_pkg::rsp_type rsp_data
);
   import mfkt_pkg::*;

   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(KEY_SLOTS - 1);

   state_type state_ff, state_in;
   req_type   req_ff, req_in;
   logic [KEY_SLOTS-1:0] valid_ff, valid_in;
   logic [SLOT_W-1:0] ptr_ff, ptr_in;      // address issued this cycle
   logic [SLOT_W-1:0] prev_ff, prev_in;    // address whose data is on rd_data
   logic              rdv_ff, rdv_in;      // rd_data holds a scanned entry
   logic              hit_ff, hit_in;
   logic [SLOT_W-1:0] hs_ff, hs_in;        // hit / best slot
   logic              free_ff, free_in;
   logic [SLOT_W-1:0] fs_ff, fs_in;
   entry_type         ent_ff, ent_in;      // entry of the touched or best slot
   logic              isnew_ff, isnew_in;
   logic              freed_ff, freed_in;
   logic [AGE_W-1:0]  oage_ff, oage_in;
   logic [ROW_W-1:0]  rc_ff, rc_in;       // row scan index
   logic              emitted_ff, emitted_in;

   logic [SLOT_W-1:0] rd_addr, wr_addr;
   entry_type         rd_data, wr_data;
   logic              wr_en;

   mfkt_table u_table (
      .clock   (clock),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         valid_ff <= '0;
         rdv_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
         rdv_ff   <= rdv_in;
      end
      req_ff     <= req_in;
      ptr_ff     <= ptr_in;
      prev_ff    <= prev_in;
      hit_ff     <= hit_in;
      hs_ff      <= hs_in;
      free_ff    <= free_in;
      fs_ff      <= fs_in;
      ent_ff     <= ent_in;
      isnew_ff   <= isnew_in;
      freed_ff   <= freed_in;
      oage_ff    <= oage_in;
      rc_ff      <= rc_in;
      emitted_ff <= emitted_in;
   end

   logic [CNT_W-1:0] new_cnt;
   logic             row_ok;
   assign row_ok = ({1'b0, req_ff.row} < 7'(ROW_COUNT));

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               if (req_data.command == CMD_QUERY) begin
                  state_in = (valid_ff == '0) ? S_QEMIT : S_QSCAN;
               end else if (req_data.command != CMD_UNDEF) begin
                  state_in = S_FIND;
               end
            end
         end
         S_FIND:   if (rdv_ff && prev_ff == LAST_SLOT) state_in = S_DECIDE;
         S_DECIDE: begin
            if (!row_ok || (req_ff.command == CMD_ADD && !hit_ff && !free_ff) ||
                (req_ff.command == CMD_REMOVE && !hit_ff)) begin
               state_in = S_IDLE;
            end else begin
               state_in = S_BITS;
            end
         end
         S_BITS:   state_in = S_AGE_RD;
         S_AGE_RD: state_in = S_AGE_WR;
         S_AGE_WR: state_in = (ptr_ff == LAST_SLOT) ? S_IDLE : S_AGE_RD;
         S_QSCAN:  if (rdv_ff && prev_ff == LAST_SLOT) state_in = S_QREAD;
         S_QREAD:  state_in = S_QEMIT;
         S_QEMIT: begin
            if (valid_ff == '0 && !rdv_ff) state_in = S_IDLE;
            else if (rc_ff == ROW_W'(ROW_COUNT - 1)) state_in = S_IDLE;
         end
         default:  state_in = S_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      entry_type e;
      logic      ok;
      logic [ROW_COUNT-1:0] rem;
      req_in     = req_ff;
      valid_in   = valid_ff;
      ptr_in     = ptr_ff;
      prev_in    = ptr_ff;
      rdv_in     = 1'b0;
      hit_in     = hit_ff;
      hs_in      = hs_ff;
      free_in    = free_ff;
      fs_in      = fs_ff;
      ent_in     = ent_ff;
      isnew_in   = isnew_ff;
      freed_in   = freed_ff;
      oage_in    = oage_ff;
      rc_in      = rc_ff;
      emitted_in = emitted_ff;
      rd_addr    = ptr_ff;
      wr_en      = 1'b0;
      wr_addr    = ptr_ff;
      wr_data    = rd_data;
      rsp_valid  = 1'b0;
      rsp_data   = '0;
      busy       = (state_ff != S_IDLE);
      new_cnt    = '0;
      e          = rd_data;
      ok         = 1'b0;
      rem        = '0;

      unique case (state_ff)
         S_IDLE: begin
            req_in     = req_data;
            ptr_in     = '0;
            rd_addr    = '0;
            hit_in     = 1'b0;
            free_in    = 1'b0;
            rc_in      = '0;
            emitted_in = 1'b0;
            if (start && req_data.command != CMD_UNDEF &&
                !(req_data.command == CMD_QUERY && valid_ff == '0)) begin
               rdv_in = 1'b1;
               ptr_in = SLOT_W'(1);
               prev_in = '0;
            end
         end
         S_FIND: begin
            rd_addr = ptr_ff;
            if (ptr_ff != LAST_SLOT) ptr_in = ptr_ff + 1'b1;
            rdv_in = (prev_ff != LAST_SLOT);
            if (valid_ff[prev_ff] && !hit_ff && rd_data.key == req_ff.key[KEY_BITS-1:0]) begin
               hit_in = 1'b1;
               hs_in  = prev_ff;
               ent_in = rd_data;
            end
            if (!valid_ff[prev_ff] && !free_ff) begin
               free_in = 1'b1;
               fs_in   = prev_ff;
            end
         end
         S_DECIDE: begin
            rsp_data.key_res = req_ff.key;
            rsp_data.row_res = req_ff.row;
            rsp_data.last    = 1'b1;
            rsp_data.status  = ST_OK;
            e = ent_ff;
            if (!hit_ff) begin
               e.rows = '0;
               e.key  = req_ff.key[KEY_BITS-1:0];
            end
            if (!row_ok) begin
               rsp_valid = 1'b1;
               rsp_data.frequency = hit_ff ? 7'(ent_ff.count) : 7'd0;
            end else if (req_ff.command == CMD_ADD && !hit_ff && !free_ff) begin
               rsp_valid = 1'b1;
               rsp_data.status = ST_FULL;
            end else if (req_ff.command == CMD_REMOVE && !hit_ff) begin
               rsp_valid = 1'b1;
            end else begin
               ok = 1'b1;
            end
            if (req_ff.command == CMD_ADD) e.rows[req_ff.row[ROW_W-1:0]] = 1'b1;
            else e.rows[req_ff.row[ROW_W-1:0]] = 1'b0;
            new_cnt = hit_ff ? ent_ff.count : '0;
            if (req_ff.command == CMD_ADD && !(hit_ff && ent_ff.rows[req_ff.row[ROW_W-1:0]]))
               new_cnt = new_cnt + 1'b1;
            if (req_ff.command == CMD_REMOVE && ent_ff.rows[req_ff.row[ROW_W-1:0]])
               new_cnt = new_cnt - 1'b1;
            e.count = new_cnt;
            if (ok) begin
               isnew_in = !hit_ff;
               oage_in  = ent_ff.age;
               freed_in = (new_cnt == '0);
               e.age    = '0;
               ent_in   = e;
               if (!hit_ff) hs_in = fs_ff;
               rsp_valid = 1'b1;
               rsp_data.frequency = 7'(new_cnt);
            end
            ptr_in = '0;
         end
         S_BITS: begin
            // write the touched slot and its validity
            wr_en   = 1'b1;
            wr_addr = hs_ff;
            wr_data = ent_ff;
            valid_in[hs_ff] = !freed_ff;
            rd_addr = '0;
         end
         S_AGE_RD: rd_addr = ptr_ff;
         S_AGE_WR: begin
            e = rd_data;
            if (valid_ff[ptr_ff] && ptr_ff != hs_ff) begin
               if (freed_ff) begin
                  if (rd_data.age > oage_ff) e.age = rd_data.age - 1'b1;
               end else if (isnew_ff || rd_data.age < oage_ff) begin
                  e.age = rd_data.age + 1'b1;
               end
            end
            wr_en   = 1'b1;
            wr_addr = ptr_ff;
            wr_data = e;
            if (ptr_ff != LAST_SLOT) ptr_in = ptr_ff + 1'b1;
            rd_addr = ptr_in;
         end
         S_QSCAN: begin
            rd_addr = ptr_ff;
            if (ptr_ff != LAST_SLOT) ptr_in = ptr_ff + 1'b1;
            rdv_in = (prev_ff != LAST_SLOT);
            if (valid_ff[prev_ff] && (!hit_ff || rd_data.count > ent_ff.count ||
                (rd_data.count == ent_ff.count && rd_data.age < ent_ff.age))) begin
               hit_in = 1'b1;
               hs_in  = prev_ff;
               ent_in = rd_data;
            end
         end
         S_QREAD: rc_in = '0;
         S_QEMIT: begin
            if (valid_ff == '0 && !rdv_ff) begin
               rsp_valid = 1'b1;
               rsp_data.status = ST_EMPTY;
               rsp_data.last   = 1'b1;
            end else begin
               rdv_in = rdv_ff;
               rem = ent_ff.rows >> rc_ff;
               rsp_data.key_res   = 16'(ent_ff.key);
               rsp_data.frequency = 7'(ent_ff.count);
               rsp_data.row_res   = 6'(rc_ff);
               if (ent_ff.rows[rc_ff]) begin
                  rsp_valid = 1'b1;
                  emitted_in = 1'b1;
                  // last beat when no higher row is set
                  rsp_data.last = ((rem >> 1) == '0);
               end
               if (rc_ff == ROW_W'(ROW_COUNT - 1)) begin
                  if (!emitted_ff && !ent_ff.rows[rc_ff]) begin
                     rsp_valid = 1'b1;
                     rsp_data.row_res = '0;
                     rsp_data.last = 1'b1;
                  end
               end
               rc_in = rc_ff + 1'b1;
            end
         end
         default: ;
      endcase
   end
endmodule

FILE: test/most_frequent_key_tracker_tb.sv
// testbench for most_frequent_key_tracker: queued command driver, result monitor, own table model
// depends on mfkt_pkg and the most_frequent_key_tracker rtl
`timescale 1ns / 1ps

module most_frequent_key_tracker_tb;
   import mfkt_pkg::*;

   localparam int CYCLE_LIMIT = 600000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_data = '0;
   logic    rsp_valid;
   rsp_type rsp_data;

   most_frequent_key_tracker uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data)
   );

   always #4 clock = ~clock;

   // own copy of the slot table
   logic        tbl_valid [KEY_SLOTS];
   logic [15:0] tbl_key   [KEY_SLOTS];
   logic [63:0] tbl_rows  [KEY_SLOTS];
   int          tbl_count [KEY_SLOTS];
   int          tbl_age   [KEY_SLOTS];

   req_type pending_cmds[$];
   rsp_type expected_rsps[$];
   int      gap_left = 0;
   int      errors = 0;
   int      cycles = 0;
   logic [15:0] key_pool[18];

   function automatic rsp_type mk_rsp(logic [1:0] st, logic [15:0] k, logic [5:0] r,
                                      int f, logic l);
      rsp_type x;
      x.status = st; x.key_res = k; x.row_res = r; x.frequency = f[6:0]; x.last = l;
      return x;
   endfunction

   // append one expected result beat
   task automatic expect_rsp(logic [1:0] st, logic [15:0] k, logic [5:0] r,
                             int f, logic l);
      expected_rsps.insert(expected_rsps.size(), mk_rsp(st, k, r, f, l));
   endtask

   task automatic touch_slot(int s, bit is_new);
      for (int i = 0; i < KEY_SLOTS; i++)
         if (i != s && tbl_valid[i] && (is_new || tbl_age[i] < tbl_age[s]))
            tbl_age[i]++;
      tbl_age[s] = 0;
   endtask

   task automatic predict_tracker(req_type c);
      int s;
      int best;
      s = -1;
      for (int i = 0; i < KEY_SLOTS; i++)
         if (s < 0 && tbl_valid[i] && tbl_key[i] == c.key) s = i;
      case (c.command)
         CMD_ADD: begin
            if (s < 0) begin
               for (int i = 0; i < KEY_SLOTS; i++)
                  if (s < 0 && !tbl_valid[i]) s = i;
               if (s < 0) begin
                  expect_rsp(ST_FULL, c.key, c.row, 0, 1'b1);
                  return;
               end
               tbl_valid[s] = 1'b1;
               tbl_key[s] = c.key;
               tbl_rows[s] = '0;
               touch_slot(s, 1'b1);
            end else begin
               touch_slot(s, 1'b0);
            end
            tbl_rows[s][c.row] = 1'b1;
            tbl_count[s] = $countones(tbl_rows[s]);
            expect_rsp(ST_OK, c.key, c.row, tbl_count[s], 1'b1);
         end
         CMD_REMOVE: begin
            if (s < 0) begin
               expect_rsp(ST_OK, c.key, c.row, 0, 1'b1);
               return;
            end
            tbl_rows[s][c.row] = 1'b0;
            tbl_count[s] = $countones(tbl_rows[s]);
            if (tbl_count[s] == 0) begin
               for (int i = 0; i < KEY_SLOTS; i++)
                  if (i != s && tbl_valid[i] && tbl_age[i] > tbl_age[s]) tbl_age[i]--;
               tbl_valid[s] = 1'b0;
            end else begin
               touch_slot(s, 1'b0);
            end
            expect_rsp(ST_OK, c.key, c.row, tbl_count[s], 1'b1);
         end
         CMD_QUERY: begin
            best = -1;
            for (int i = 0; i < KEY_SLOTS; i++)
               if (tbl_valid[i] && (best < 0 || tbl_count[i] > tbl_count[best] ||
                   (tbl_count[i] == tbl_count[best] && tbl_age[i] < tbl_age[best])))
                  best = i;
            if (best < 0) begin
               expect_rsp(ST_EMPTY, '0, '0, 0, 1'b1);
               return;
            end
            for (int i = 0; i < ROW_COUNT; i++)
               if (tbl_rows[best][i])
                  expect_rsp(ST_OK, tbl_key[best], i[5:0], tbl_count[best], 1'b0);
            expected_rsps[$].last = 1'b1;
         end
         default: ;
      endcase
   endtask

   function automatic int pick_gap();
      int p;
      p = $urandom_range(99);
      if (p < 65) return 0;
      if (p < 95) return $urandom_range(1, 3);
      return $urandom_range(20, 60);
   endfunction

   function automatic req_type mk_cmd(logic [1:0] c, logic [15:0] k, logic [5:0] r);
      req_type x;
      x.command = c; x.key = k; x.row = r;
      return x;
   endfunction

   // append one command to the driver's queue
   task automatic queue_cmd(logic [1:0] c, logic [15:0] k, logic [5:0] r);
      pending_cmds.insert(pending_cmds.size(), mk_cmd(c, k, r));
   endtask

   // driver: a beat is taken at an edge with start high and busy low
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (start && !busy) begin
         predict_tracker(req_data);
         gap_left = pick_gap();
         if (gap_left == 0 && pending_cmds.size() > 0) begin
            req_data <= pending_cmds.pop_front();
         end else begin
            start <= 1'b0;
         end
      end else if (!start) begin
         if (gap_left > 0) begin
            gap_left--;
         end else if (pending_cmds.size() > 0) begin
            req_data <= pending_cmds.pop_front();
            start <= 1'b1;
         end
      end
   end

   // monitor: result beats last one cycle and cannot be held off
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (expected_rsps.size() == 0) begin
            $display("%0t: unexpected result beat, actual %p", $time, rsp_data);
            errors++;
         end else begin
            if (rsp_data.status !== expected_rsps[0].status ||
                rsp_data.key_res !== expected_rsps[0].key_res ||
                rsp_data.row_res !== expected_rsps[0].row_res ||
                rsp_data.frequency !== expected_rsps[0].frequency ||
                rsp_data.last !== expected_rsps[0].last) begin
               $display("%0t: mismatch, expected %p actual %p", $time,
                        expected_rsps[0], rsp_data);
               errors++;
            end
            void'(expected_rsps.pop_front());
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   initial begin
      int p;
      logic [1:0] c;
      for (int i = 0; i < KEY_SLOTS; i++) tbl_valid[i] = 1'b0;
      // directed: empty query, extremes, duplicates, unknown key, full table, undefined
      queue_cmd(CMD_QUERY, 16'h0000, 6'd0);
      queue_cmd(CMD_REMOVE, 16'h1234, 6'd5);
      queue_cmd(CMD_ADD, 16'h0000, 6'd0);
      queue_cmd(CMD_ADD, 16'hffff, 6'd63);
      queue_cmd(CMD_ADD, 16'hffff, 6'd63);
      queue_cmd(CMD_QUERY, 16'hffff, 6'd63);
      queue_cmd(CMD_REMOVE, 16'hffff, 6'd10);
      queue_cmd(CMD_UNDEF, 16'hffff, 6'd63);
      for (int i = 1; i < KEY_SLOTS - 1; i++)
         queue_cmd(CMD_ADD, 16'(i * 16'h1111 + 1), 6'(i));
      queue_cmd(CMD_ADD, 16'haaaa, 6'd7);
      queue_cmd(CMD_ADD, 16'h5555, 6'd7);
      queue_cmd(CMD_QUERY, 16'h0, 6'd0);
      queue_cmd(CMD_REMOVE, 16'h0000, 6'd0);
      queue_cmd(CMD_REMOVE, 16'hffff, 6'd63);
      // one key holding every row gives the longest query
      for (int r = 0; r < ROW_COUNT; r++)
         queue_cmd(CMD_ADD, 16'h0002, 6'(r));
      queue_cmd(CMD_QUERY, 16'h0, 6'd0);
      for (int r = 0; r < ROW_COUNT; r++)
         queue_cmd(CMD_REMOVE, 16'h0002, 6'(r));

      key_pool[0] = 16'h0000;
      key_pool[1] = 16'hffff;
      for (int i = 2; i < 18; i++) key_pool[i] = 16'($urandom());
      for (int n = 0; n < 204; n++) begin
         p = $urandom_range(99);
         if (p < 50) c = CMD_ADD;
         else if (p < 84) c = CMD_REMOVE;
         else if (p < 97) c = CMD_QUERY;
         else c = CMD_UNDEF;
         queue_cmd(c,
            ($urandom_range(9) == 0) ? 16'($urandom()) : key_pool[$urandom_range(17)],
            6'($urandom_range(ROW_COUNT - 1)));
      end

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      wait (pending_cmds.size() == 0 && !start);
      @(posedge clock);
      wait (!busy && expected_rsps.size() == 0);
      repeat (200) @(posedge clock);
      if (errors == 0 && expected_rsps.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

FILE: sim.f
sv/mfkt_pkg.sv
sv/mfkt_table.sv
sv/most_frequent_key_tracker.sv
test/most_frequent_key_tracker_tb.sv
